// ----- hdl/thlt_pkg.sv -----
// ============================================================================
// thlt_pkg: shared definitions for the tap/hold layer toggle unit
// Phase, event, mode and register codes, default sizes and the microcode
// program that sequences the datapath.
// ============================================================================
`default_nettype none

package thlt_pkg;

    // Default sizes handed to the top level.
    localparam int SLOTS_DEF      = 8;
    localparam int LAYERS_DEF     = 16;
    localparam int STAMP_BITS_DEF = 32;

    // Slot phases.
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_TAPPING   = 3'd1;
    localparam logic [2:0] PH_HOLDING   = 3'd2;
    localparam logic [2:0] PH_POST_TAP  = 3'd3;
    localparam logic [2:0] PH_POST_HOLD = 3'd4;

    // Event kinds.
    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_TAP_BEGIN  = 3'd1;
    localparam logic [2:0] EV_TAP_END    = 3'd2;
    localparam logic [2:0] EV_HOLD_BEGIN = 3'd3;
    localparam logic [2:0] EV_HOLD_END   = 3'd4;

    // Input modes.
    localparam logic [1:0] MODE_PRESS   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_TICK    = 2'd2;

    // Register indexes (word address).
    localparam logic [2:0] REG_SLOTS_IN_USE  = 3'd0;
    localparam logic [2:0] REG_TAP_TERM      = 3'd1;
    localparam logic [2:0] REG_TAP_INTERVAL  = 3'd2;
    localparam logic [2:0] REG_LAYER_TABLE   = 3'd3;
    localparam logic [2:0] REG_TARGET_TABLE  = 3'd4;

    // Register reset values.
    localparam logic [15:0] TAP_TERM_RST     = 16'd200;
    localparam logic [15:0] TAP_INTERVAL_RST = 16'd500;

    // Micro-operations of the datapath.
    localparam logic [2:0] OP_WAIT   = 3'd0;
    localparam logic [2:0] OP_NOP    = 3'd1;
    localparam logic [2:0] OP_SCAN   = 3'd2;
    localparam logic [2:0] OP_FINISH = 3'd3;
    localparam logic [2:0] OP_KEY    = 3'd4;

    // Jump conditions.
    localparam logic [1:0] C_ALWAYS    = 2'd0;
    localparam logic [1:0] C_NO_ITEM   = 2'd1;
    localparam logic [1:0] C_NOT_TICK  = 2'd2;
    localparam logic [1:0] C_SCAN_MORE = 2'd3;

    // Program steps.
    localparam logic [2:0] ST_WAIT     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_FINISH   = 3'd3;
    localparam logic [2:0] ST_KEY      = 3'd4;

    // One control word: the operation, and where to go when the condition holds.
    typedef struct packed {
        logic [2:0] op;
        logic [1:0] cond;
        logic [2:0] target;
    } ucode_t;

    // The control store. A step that fails its condition falls through to the next.
    function automatic ucode_t ucode_rom(input logic [2:0] step);
        ucode_t w;
        case (step)
            ST_WAIT:     w = '{op: OP_WAIT,   cond: C_NO_ITEM,   target: ST_WAIT};
            ST_DISPATCH: w = '{op: OP_NOP,    cond: C_NOT_TICK,  target: ST_KEY};
            ST_SCAN:     w = '{op: OP_SCAN,   cond: C_SCAN_MORE, target: ST_SCAN};
            ST_FINISH:   w = '{op: OP_FINISH, cond: C_ALWAYS,    target: ST_WAIT};
            ST_KEY:      w = '{op: OP_KEY,    cond: C_ALWAYS,    target: ST_WAIT};
            default:     w = '{op: OP_NOP,    cond: C_ALWAYS,    target: ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tap_hold_layer_toggle_unit.sv -----
// ============================================================================
// tap_hold_layer_toggle_unit: tap/hold qualifier for tap-toggle layer keys
// Tracks the phase, tap count and time stamp of each slot, and reports tap
// and hold events together with the resulting layer bits.
// ============================================================================
// Usage:
// Items (mode, slot, now_ticks) enter on item_valid / item_stall; a word is
// taken at an edge with item_valid high and item_stall low. Each item gives
// one result word or more on result_valid / result_stall; last marks the
// final word of an item. Configuration is written over the APB-style port.
// A microcoded sequencer runs the work: a press or release goes through the
// accept, dispatch and key steps to its result in the output register. A scan
// tick walks the active slots one per cycle through the shared slot datapath,
// save while a step that must emit a word waits for the output register, and
// a finish step then emits the last word. A new item is taken only when the
// sequencer is back in its wait step: no item enters before the last is done.
// While the receiver stalls, the output register holds its word and any
// step that must emit another word waits, so no result is lost.
// Reset clears all slot phases, tap counts, stamps and layer bits, sets the
// registers to their reset values and empties the output register.
// ============================================================================
`default_nettype none

module tap_hold_layer_toggle_unit
    import thlt_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int LAYERS     = LAYERS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Item channel
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [2:0]  slot,
    input  wire logic [31:0] now_ticks,
    // Result channel
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [2:0]       event_kind,
    output logic [2:0]       event_slot,
    output logic [15:0]      layers_on,
    output logic             last,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CUR_W   = (IDX_W > 3) ? IDX_W : 3;
    localparam int LAY_W   = (LAYERS > 16) ? LAYERS : 16;
    localparam int NOW_W   = (STAMP_BITS > 32) ? STAMP_BITS : 32;
    localparam int LIM     = (SLOTS < 8) ? SLOTS : 8;

    // Configuration registers.
    logic [3:0]  slots_in_use_reg;
    logic [15:0] tap_term_reg;
    logic [15:0] tap_interval_reg;
    logic [31:0] layer_table_reg;
    logic [31:0] target_table_reg;

    // Slot state.
    logic [2:0]            phase_reg [SLOTS];
    logic [2:0]            phase_next [SLOTS];
    logic [3:0]            tally_reg [SLOTS];
    logic [3:0]            tally_next [SLOTS];
    logic [STAMP_BITS-1:0] stamp_reg [SLOTS];
    logic [STAMP_BITS-1:0] stamp_next [SLOTS];
    logic [LAYERS-1:0]     active_reg;
    logic [LAYERS-1:0]     active_next;

    // Sequencer and latched item.
    logic [2:0]            pc_reg;
    logic [2:0]            pc_next;
    logic [1:0]            mode_reg;
    logic [1:0]            mode_next;
    logic [2:0]            slot_reg;
    logic [2:0]            slot_next;
    logic [STAMP_BITS-1:0] now_reg;
    logic [STAMP_BITS-1:0] now_next;
    logic [2:0]            idx_reg;
    logic [2:0]            idx_next;

    // Hold-begin word waiting until the scan knows whether it is the last.
    logic        pend_valid_reg;
    logic        pend_valid_next;
    logic [2:0]  pend_slot_reg;
    logic [2:0]  pend_slot_next;
    logic [15:0] pend_layers_reg;
    logic [15:0] pend_layers_next;

    // Output register.
    logic        res_valid_reg;
    logic        res_valid_next;
    logic [2:0]  ev_kind_reg;
    logic [2:0]  ev_kind_next;
    logic [2:0]  ev_slot_reg;
    logic [2:0]  ev_slot_next;
    logic [15:0] ev_layers_reg;
    logic [15:0] ev_layers_next;
    logic        ev_last_reg;
    logic        ev_last_next;

    ucode_t                uw;
    logic                  item_accept;
    logic                  out_free;
    logic                  needs_out;
    logic                  go;
    logic                  emit;
    logic                  cond_true;
    logic [3:0]            n_active;
    logic [2:0]            cur3;
    logic [CUR_W-1:0]      cur_wide;
    logic [IDX_W-1:0]      cur_idx;
    logic [2:0]            cur_phase;
    logic [3:0]            cur_tally;
    logic [3:0]            tally_inc;
    logic [STAMP_BITS-1:0] cur_stamp;
    logic [STAMP_BITS-1:0] dt;
    logic                  term_hit;
    logic                  interval_hit;
    logic                  in_range;
    logic [3:0]            lay_nib;
    logic [3:0]            tgt_nib;
    logic                  layer_ok;
    logic [LAYERS-1:0]     layer_mask;
    logic [LAY_W-1:0]      lay_on_w;
    logic [LAY_W-1:0]      lay_off_w;
    logic [LAY_W-1:0]      lay_cur_w;
    logic [15:0]           lay16_on;
    logic [15:0]           lay16_off;
    logic [15:0]           lay16_cur;
    logic [NOW_W-1:0]      now_w;
    logic                  cfg_write;

    // Control word of the current step, and the handshakes.
    assign uw          = ucode_rom(pc_reg);
    assign item_stall  = (uw.op != OP_WAIT);
    assign item_accept = item_valid && !item_stall;
    assign out_free    = !res_valid_reg || !result_stall;

    // Active slot count, capped at the slot storage and at eight.
    assign n_active = (slots_in_use_reg > 4'(LIM)) ? 4'(LIM) : slots_in_use_reg;

    // One slot is addressed per step: the scan index or the item's slot.
    assign cur3      = (uw.op == OP_SCAN) ? idx_reg : slot_reg;
    assign cur_wide  = CUR_W'(cur3);
    assign cur_idx   = cur_wide[IDX_W-1:0];
    assign cur_phase = phase_reg[cur_idx];
    assign cur_tally = tally_reg[cur_idx];
    assign cur_stamp = stamp_reg[cur_idx];
    assign in_range  = ({1'b0, cur3} < n_active);
    assign tally_inc = (cur_tally == 4'd15) ? 4'd15 : cur_tally + 4'd1;

    // Elapsed time, modulo the stamp width.
    assign dt           = now_reg - cur_stamp;
    assign term_hit     = (dt >= STAMP_BITS'(tap_term_reg));
    assign interval_hit = (dt >= STAMP_BITS'(tap_interval_reg));

    // Per-slot table fields and the layer bit of the addressed slot.
    assign lay_nib    = layer_table_reg[{cur3, 2'b00} +: 4];
    assign tgt_nib    = target_table_reg[{cur3, 2'b00} +: 4];
    assign layer_ok   = ({28'd0, lay_nib} < 32'(LAYERS));
    assign layer_mask = layer_ok ? (LAYERS'(1) << lay_nib) : '0;

    // Layer bits as seen on the port after setting, clearing or keeping.
    assign lay_on_w  = LAY_W'(active_reg | layer_mask);
    assign lay_off_w = LAY_W'(active_reg & ~layer_mask);
    assign lay_cur_w = LAY_W'(active_reg);
    assign lay16_on  = lay_on_w[15:0];
    assign lay16_off = lay_off_w[15:0];
    assign lay16_cur = lay_cur_w[15:0];

    assign now_w = NOW_W'(now_ticks);

    // Datapath: the current micro-operation acting on the addressed slot.
    always_comb
    begin
        phase_next       = phase_reg;
        tally_next       = tally_reg;
        stamp_next       = stamp_reg;
        active_next      = active_reg;
        mode_next        = mode_reg;
        slot_next        = slot_reg;
        now_next         = now_reg;
        idx_next         = idx_reg;
        pend_valid_next  = pend_valid_reg;
        pend_slot_next   = pend_slot_reg;
        pend_layers_next = pend_layers_reg;
        emit             = 1'b0;
        ev_kind_next     = ev_kind_reg;
        ev_slot_next     = ev_slot_reg;
        ev_layers_next   = ev_layers_reg;
        ev_last_next     = ev_last_reg;
        needs_out        = 1'b0;

        // Steps that must write a word wait for the output register.
        case (uw.op)
            OP_SCAN:   needs_out = in_range && (cur_phase == PH_TAPPING) && term_hit
                                   && pend_valid_reg;
            OP_FINISH: needs_out = 1'b1;
            OP_KEY:    needs_out = 1'b1;
            default:   needs_out = 1'b0;
        endcase
        go = !needs_out || out_free;

        case (uw.op)
            OP_WAIT:
            begin
                if (item_accept)
                begin
                    mode_next       = mode;
                    slot_next       = slot;
                    now_next        = now_w[STAMP_BITS-1:0];
                    idx_next        = 3'd0;
                    pend_valid_next = 1'b0;
                end
            end
            OP_SCAN:
            begin
                if (go)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (in_range)
                    begin
                        case (cur_phase)
                            PH_IDLE:
                            begin
                                if (interval_hit)
                                begin
                                    tally_next[cur_idx] = 4'd0;
                                    stamp_next[cur_idx] = now_reg;
                                end
                            end
                            PH_TAPPING:
                            begin
                                if (term_hit)
                                begin
                                    phase_next[cur_idx] = PH_HOLDING;
                                    active_next         = active_reg | layer_mask;
                                    // An earlier hold-begin is now known not to be last.
                                    if (pend_valid_reg)
                                    begin
                                        emit           = 1'b1;
                                        ev_kind_next   = EV_HOLD_BEGIN;
                                        ev_slot_next   = pend_slot_reg;
                                        ev_layers_next = pend_layers_reg;
                                        ev_last_next   = 1'b0;
                                    end
                                    pend_valid_next  = 1'b1;
                                    pend_slot_next   = cur3;
                                    pend_layers_next = lay16_on;
                                end
                            end
                            PH_POST_TAP:
                            begin
                                phase_next[cur_idx] = PH_IDLE;
                            end
                            PH_POST_HOLD:
                            begin
                                phase_next[cur_idx] = PH_IDLE;
                                tally_next[cur_idx] = 4'd0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            OP_FINISH:
            begin
                if (go)
                begin
                    emit         = 1'b1;
                    ev_last_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        ev_kind_next   = EV_HOLD_BEGIN;
                        ev_slot_next   = pend_slot_reg;
                        ev_layers_next = pend_layers_reg;
                    end
                    else
                    begin
                        ev_kind_next   = EV_NONE;
                        ev_slot_next   = 3'd0;
                        ev_layers_next = lay16_cur;
                    end
                end
            end
            OP_KEY:
            begin
                if (go)
                begin
                    emit           = 1'b1;
                    ev_last_next   = 1'b1;
                    ev_kind_next   = EV_NONE;
                    ev_slot_next   = 3'd0;
                    ev_layers_next = lay16_cur;
                    if (mode_reg == MODE_PRESS)
                    begin
                        if (in_range && (cur_phase == PH_IDLE))
                        begin
                            phase_next[cur_idx] = PH_TAPPING;
                            stamp_next[cur_idx] = now_reg;
                            active_next         = active_reg | layer_mask;
                            ev_kind_next        = EV_TAP_BEGIN;
                            ev_slot_next        = cur3;
                            ev_layers_next      = lay16_on;
                        end
                    end
                    else if (mode_reg == MODE_RELEASE)
                    begin
                        if (in_range && (cur_phase == PH_TAPPING))
                        begin
                            phase_next[cur_idx] = PH_POST_TAP;
                            ev_kind_next        = EV_TAP_END;
                            ev_slot_next        = cur3;
                            // Enough taps latch the layer on and restart the count.
                            if (tally_inc >= tgt_nib)
                            begin
                                tally_next[cur_idx] = 4'd0;
                                ev_layers_next      = lay16_cur;
                            end
                            else
                            begin
                                tally_next[cur_idx] = tally_inc;
                                active_next         = active_reg & ~layer_mask;
                                ev_layers_next      = lay16_off;
                            end
                        end
                        else if (in_range && (cur_phase == PH_HOLDING))
                        begin
                            phase_next[cur_idx] = PH_POST_HOLD;
                            active_next         = active_reg & ~layer_mask;
                            ev_kind_next        = EV_HOLD_END;
                            ev_slot_next        = cur3;
                            ev_layers_next      = lay16_off;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Output register: load on emit, drop once the word is taken.
        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // Sequencer: conditional jump or fall through, held while a step waits.
    always_comb
    begin
        case (uw.cond)
            C_ALWAYS:    cond_true = 1'b1;
            C_NO_ITEM:   cond_true = !item_accept;
            C_NOT_TICK:  cond_true = (mode_reg != MODE_TICK);
            C_SCAN_MORE: cond_true = (({1'b0, idx_reg} + 4'd1) < n_active);
            default:     cond_true = 1'b1;
        endcase
        if (!go)
        begin
            pc_next = pc_reg;
        end
        else if (cond_true)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = pc_reg + 3'd1;
        end
    end

    // Control and slot state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= ST_WAIT;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            active_reg     <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                phase_reg[i] <= PH_IDLE;
                tally_reg[i] <= 4'd0;
                stamp_reg[i] <= '0;
            end
        end
        else
        begin
            pc_reg         <= pc_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
            active_reg     <= active_next;
            phase_reg      <= phase_next;
            tally_reg      <= tally_next;
            stamp_reg      <= stamp_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        slot_reg        <= slot_next;
        now_reg         <= now_next;
        idx_reg         <= idx_next;
        pend_slot_reg   <= pend_slot_next;
        pend_layers_reg <= pend_layers_next;
        ev_kind_reg     <= ev_kind_next;
        ev_slot_reg     <= ev_slot_next;
        ev_layers_reg   <= ev_layers_next;
        ev_last_reg     <= ev_last_next;
    end

    // Configuration writes.
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= 4'd0;
            tap_term_reg     <= TAP_TERM_RST;
            tap_interval_reg <= TAP_INTERVAL_RST;
            layer_table_reg  <= 32'd0;
            target_table_reg <= 32'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_SLOTS_IN_USE: slots_in_use_reg <= pwdata[3:0];
                REG_TAP_TERM:     tap_term_reg     <= pwdata[15:0];
                REG_TAP_INTERVAL: tap_interval_reg <= pwdata[15:0];
                REG_LAYER_TABLE:  layer_table_reg  <= pwdata;
                REG_TARGET_TABLE: target_table_reg <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    // Configuration reads.
    always_comb
    begin
        case (paddr[4:2])
            REG_SLOTS_IN_USE: prdata = {28'd0, slots_in_use_reg};
            REG_TAP_TERM:     prdata = {16'd0, tap_term_reg};
            REG_TAP_INTERVAL: prdata = {16'd0, tap_interval_reg};
            REG_LAYER_TABLE:  prdata = layer_table_reg;
            REG_TARGET_TABLE: prdata = target_table_reg;
            default:          prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    // Result ports.
    assign result_valid = res_valid_reg;
    assign event_kind   = ev_kind_reg;
    assign event_slot   = ev_slot_reg;
    assign layers_on    = ev_layers_reg;
    assign last         = ev_last_reg;

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the tap/hold layer toggle unit
// Drives press, release and scan-tick words under several register settings,
// predicts event words in the bench or takes them from the directed rows, and
// compares each result word field by field. Both channels idle at random; the
// receiver holds off once for long, so the unit backs up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
    import thlt_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DIRECTED_ROWS = 25;
    localparam int RESET_ROWS    = 2;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 65;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 300;

    // The unused mode code has no name in the package.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [2:0]  kind;
        logic [2:0]  ev_slot;
        logic [15:0] layers;
        logic        last;
    } event_word_t;

    typedef struct {
        logic [1:0]  mode;
        logic [2:0]  key_slot;
        logic [31:0] stamp;
        bit          typed;
        logic [2:0]  want_kind;
        logic [2:0]  want_slot;
        logic [15:0] want_layers;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  mode;
    logic [2:0]  slot;
    logic [31:0] now_ticks;
    logic        result_valid;
    logic        result_stall;
    logic [2:0]  event_kind;
    logic [2:0]  event_slot;
    logic [15:0] layers_on;
    logic        last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tap_hold_layer_toggle_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .slot         (slot),
        .now_ticks    (now_ticks),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .event_kind   (event_kind),
        .event_slot   (event_slot),
        .layers_on    (layers_on),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Register shadows, kept in step with every write.
    logic [3:0]  cfg_slots;
    logic [15:0] cfg_term;
    logic [15:0] cfg_interval;
    logic [31:0] cfg_layer_tab;
    logic [31:0] cfg_target_tab;

    // Predicted slot state.
    logic [2:0]  slot_phase_q  [8];
    logic [3:0]  tap_count_q   [8];
    logic [31:0] press_stamp_q [8];
    logic [15:0] layer_bits_q;

    event_word_t step_words[$];
    event_word_t expected_words[$];
    stim_row_t   directed_rows [DIRECTED_ROWS];

    int          mismatch_count;
    int          cycle_count;
    bit          quiet_phase;
    bit          hold_request;
    logic [31:0] now_cursor;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run-time limit.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Predictor helpers.
    function automatic void drive_layer(input int s, input bit on);
        int l;
        l = int'(cfg_layer_tab[4*s +: 4]);
        if (l < 16)
            layer_bits_q[l] = on;
    endfunction

    function automatic void add_event(input logic [2:0] kind, input int s);
        event_word_t w;
        w.kind    = kind;
        w.ev_slot = 3'(s);
        w.layers  = layer_bits_q;
        w.last    = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic bit span_reached(input int s, input logic [31:0] t, input logic [15:0] lim);
        logic [31:0] d;
        d = t - press_stamp_q[s];
        return d >= {16'd0, lim};
    endfunction

    // Works out the event words of one item and advances the predicted state.
    function automatic void qualify_item(input logic [1:0] m, input logic [2:0] s,
                                         input logic [31:0] t);
        int n_act;
        int k;
        int i;
        step_words.delete();
        n_act = (cfg_slots > 4'd8) ? 8 : int'(cfg_slots);
        k = int'(s);
        if (m == MODE_PRESS)
        begin
            if (k < n_act && slot_phase_q[k] == PH_IDLE)
            begin
                slot_phase_q[k] = PH_TAPPING;
                press_stamp_q[k] = t;
                drive_layer(k, 1'b1);
                add_event(EV_TAP_BEGIN, k);
            end
        end
        else if (m == MODE_RELEASE)
        begin
            if (k < n_act && slot_phase_q[k] == PH_TAPPING)
            begin
                slot_phase_q[k] = PH_POST_TAP;
                if (tap_count_q[k] < 4'd15)
                    tap_count_q[k] = tap_count_q[k] + 4'd1;
                if (tap_count_q[k] >= cfg_target_tab[4*k +: 4])
                    tap_count_q[k] = 4'd0;
                else
                    drive_layer(k, 1'b0);
                add_event(EV_TAP_END, k);
            end
            else if (k < n_act && slot_phase_q[k] == PH_HOLDING)
            begin
                slot_phase_q[k] = PH_POST_HOLD;
                drive_layer(k, 1'b0);
                add_event(EV_HOLD_END, k);
            end
        end
        else if (m == MODE_TICK)
        begin
            for (i = 0; i < n_act; i++)
            begin
                case (slot_phase_q[i])
                    PH_IDLE:
                    begin
                        if (span_reached(i, t, cfg_interval))
                        begin
                            tap_count_q[i] = 4'd0;
                            press_stamp_q[i] = t;
                        end
                    end
                    PH_TAPPING:
                    begin
                        if (span_reached(i, t, cfg_term))
                        begin
                            slot_phase_q[i] = PH_HOLDING;
                            drive_layer(i, 1'b1);
                            add_event(EV_HOLD_BEGIN, i);
                        end
                    end
                    PH_POST_TAP:
                        slot_phase_q[i] = PH_IDLE;
                    PH_POST_HOLD:
                    begin
                        slot_phase_q[i] = PH_IDLE;
                        tap_count_q[i] = 4'd0;
                    end
                    default:
                        ;
                endcase
            end
        end
        if (step_words.size() == 0)
            add_event(EV_NONE, 0);
        step_words[step_words.size() - 1].last = 1'b1;
    endfunction

    // Result checker: every word taken is compared with the oldest expectation.
    always @(posedge clk)
    begin : check_words
        event_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_words.size() == 0)
                report_mismatch("word with none expected, kind", event_kind, EV_NONE);
            else
            begin
                want = expected_words.pop_front();
                if (event_kind !== want.kind)
                    report_mismatch("event_kind", event_kind, want.kind);
                if (event_slot !== want.ev_slot)
                    report_mismatch("event_slot", event_slot, want.ev_slot);
                if (layers_on !== want.layers)
                    report_mismatch("layers_on", layers_on, want.layers);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !quiet_phase && ($urandom_range(0, 99) < 9);
        end
    end

    // Offers one word and records its expected results once it is taken.
    task automatic offer_item(input stim_row_t r);
        event_word_t w;
        @(negedge clk);
        while (!quiet_phase && $urandom_range(0, 99) < 9)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        mode       <= r.mode;
        slot       <= r.key_slot;
        now_ticks  <= r.stamp;
        do
            @(posedge clk);
        while (item_stall);
        qualify_item(r.mode, r.key_slot, r.stamp);
        if (r.typed)
        begin
            w.kind    = r.want_kind;
            w.ev_slot = r.want_slot;
            w.layers  = r.want_layers;
            w.last    = 1'b1;
            expected_words.push_back(w);
        end
        else
            foreach (step_words[i])
                expected_words.push_back(step_words[i]);
    endtask

    // Stops offering and waits until the unit has delivered everything.
    task automatic quiesce();
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_SLOTS_IN_USE: cfg_slots      = val[3:0];
            REG_TAP_TERM:     cfg_term       = val[15:0];
            REG_TAP_INTERVAL: cfg_interval   = val[15:0];
            REG_LAYER_TABLE:  cfg_layer_tab  = val;
            REG_TARGET_TABLE: cfg_target_tab = val;
            default:          ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all(input logic [3:0] n, input logic [15:0] term,
                             input logic [15:0] interval, input logic [31:0] layer_tab,
                             input logic [31:0] target_tab);
        write_reg(REG_SLOTS_IN_USE, {28'd0, n});
        write_reg(REG_TAP_TERM, {16'd0, term});
        write_reg(REG_TAP_INTERVAL, {16'd0, interval});
        write_reg(REG_LAYER_TABLE, layer_tab);
        write_reg(REG_TARGET_TABLE, target_tab);
    endtask

    // Random word: time moves mostly in small steps, now and then past the
    // term or interval, rarely anywhere. Most keys follow their own phase.
    task automatic random_item(output stim_row_t r);
        int unsigned span;
        int unsigned advance;
        int unsigned pick;
        int          n_act;
        logic [2:0]  s;
        span = (cfg_term != 16'd0) ? int'(cfg_term) : 8;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            advance = $urandom_range(0, span / 3 + 1);
        else if (pick < 97)
            advance = $urandom_range(span, 2 * span + int'(cfg_interval));
        else
            advance = $urandom;
        now_cursor = now_cursor + advance;
        n_act = (cfg_slots > 4'd8) ? 8 : int'(cfg_slots);
        s = (n_act > 0) ? 3'($urandom_range(0, n_act - 1)) : 3'($urandom_range(0, 7));
        r.stamp       = now_cursor;
        r.key_slot    = s;
        r.typed       = 1'b0;
        r.want_kind   = EV_NONE;
        r.want_slot   = 3'd0;
        r.want_layers = 16'd0;
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            r.mode     = 2'($urandom_range(0, 3));
            r.key_slot = 3'($urandom_range(0, 7));
        end
        else if (pick < 30)
            r.mode = MODE_TICK;
        else if (pick < 88)
        begin
            case (slot_phase_q[s])
                PH_IDLE:                r.mode = MODE_PRESS;
                PH_TAPPING, PH_HOLDING: r.mode = MODE_RELEASE;
                default:                r.mode = MODE_TICK;
            endcase
        end
        else
            r.mode = ($urandom_range(0, 1) == 0) ? MODE_PRESS : MODE_RELEASE;
    endtask

    // Stimulus and final verdict.
    initial
    begin : stimulus
        stim_row_t r;
        item_valid = 1'b0;
        mode       = MODE_PRESS;
        slot       = 3'd0;
        now_ticks  = 32'd0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = 5'd0;
        pwdata     = 32'd0;
        rst_n      = 1'b0;
        quiet_phase  = 1'b0;
        hold_request = 1'b0;
        mismatch_count = 0;
        now_cursor   = 32'd10;

        cfg_slots      = 4'd0;
        cfg_term       = TAP_TERM_RST;
        cfg_interval   = TAP_INTERVAL_RST;
        cfg_layer_tab  = 32'd0;
        cfg_target_tab = 32'd0;
        for (int i = 0; i < 8; i++)
        begin
            slot_phase_q[i]  = PH_IDLE;
            tap_count_q[i]   = 4'd0;
            press_stamp_q[i] = 32'd0;
        end
        layer_bits_q = 16'd0;

        // Directed words. The first two run with no active slot.
        directed_rows = '{
            '{MODE_PRESS,   3'd0, 32'd0,        1'b1, EV_NONE,       3'd0, 16'h0000},
            '{MODE_TICK,    3'd0, 32'd0,        1'b1, EV_NONE,       3'd0, 16'h0000},
            '{MODE_PRESS,   3'd0, 32'd0,        1'b1, EV_TAP_BEGIN,  3'd0, 16'h8000},
            '{MODE_RELEASE, 3'd0, 32'd1,        1'b1, EV_TAP_END,    3'd0, 16'h8000},
            '{MODE_TICK,    3'd0, 32'd2,        1'b1, EV_NONE,       3'd0, 16'h8000},
            '{MODE_PRESS,   3'd1, 32'd3,        1'b1, EV_TAP_BEGIN,  3'd1, 16'h8002},
            '{MODE_TICK,    3'd0, 32'd13,       1'b0, EV_NONE,       3'd0, 16'h0000},
            '{MODE_RELEASE, 3'd1, 32'd14,       1'b0, EV_NONE,       3'd0, 16'h0000},
            '{MODE_PRESS,   3'd1, 32'd15,       1'b1, EV_NONE,       3'd0, 16'h8000},
            '{MODE_UNUSED,  3'd7, 32'hFFFFFFFF, 1'b1, EV_NONE,       3'd0, 16'h8000},
            '{MODE_TICK,    3'd5, 32'hFFFFFFFF, 1'b0, EV_NONE,       3'd0, 16'h0000},
            '{MODE_PRESS,   3'd7, 32'd5,        1'b0, EV_NONE,       3'd0, 16'h0000},
            '{MODE_RELEASE, 3'd7, 32'd6,        1'b0, EV_NONE,       3'd0, 16'h0000},
            '{MODE_RELEASE, 3'd7, 32'd7,        1'b0, EV_NONE,       3'd0, 16'h0000},
            '{MODE_TICK,    3'd0, 32'd8,        1'b0, EV_NONE,       3'd0, 16'h0000},
            '{MODE_PRESS,   3'd4, 32'hFFFFFFF8, 1'b0, EV_NONE,       3'd0, 16'h0000},
            '{MODE_PRESS,   3'd2, 32'hFFFFFFF9, 1'b0, EV_NONE,       3'd0, 16'h0000},
            '{MODE_PRESS,   3'd3, 32'hFFFFFFFA, 1'b0, EV_NONE,       3'd0, 16'h0000},
            '{MODE_TICK,    3'd0, 32'd2,        1'b0, EV_NONE,       3'd0, 16'h0000},
            '{MODE_RELEASE, 3'd2, 32'd3,        1'b0, EV_NONE,       3'd0, 16'h0000},
            '{MODE_RELEASE, 3'd3, 32'd3,        1'b0, EV_NONE,       3'd0, 16'h0000},
            '{MODE_RELEASE, 3'd4, 32'd3,        1'b0, EV_NONE,       3'd0, 16'h0000},
            '{MODE_TICK,    3'd0, 32'd4,        1'b0, EV_NONE,       3'd0, 16'h0000},
            '{MODE_PRESS,   3'd5, 32'd4,        1'b0, EV_NONE,       3'd0, 16'h0000},
            '{MODE_RELEASE, 3'd5, 32'd5,        1'b0, EV_NONE,       3'd0, 16'h0000}
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Slot 0 latches its layer on every tap; slot 7 needs fifteen taps.
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (i == RESET_ROWS)
            begin
                quiesce();
                write_all(4'd8, 16'd10, 16'd20, 32'h7654321F, 32'hF0000210);
            end
            offer_item(directed_rows[i]);
        end
        quiesce();

        // Random phases, each under its own register setting.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: write_all(4'd8, 16'd40, 16'd120, $urandom, $urandom & 32'h33333333);
                1: write_all(4'd15, 16'd0, 16'd0, 32'hFFFFFFFF, 32'hFFFFFFFF);
                2: write_all(4'd3, 16'hFFFF, 16'hFFFF, 32'd0, 32'd0);
                3: write_all(4'd8, 16'($urandom_range(1, 64)), 16'($urandom_range(16, 256)),
                             $urandom, $urandom);
                4: write_all(4'd1, 16'd8, 16'd30, $urandom, 32'h00000002);
                default: write_all(4'd8, 16'd25, 16'd90, $urandom, $urandom & 32'h11111111);
            endcase
            // The receiver holds off in the first phase; the last one runs without gaps.
            hold_request = (p == 0);
            quiet_phase  = (p == PHASES - 1);
            for (int j = 0; j < PHASE_ITEMS; j++)
            begin
                random_item(r);
                offer_item(r);
            end
            quiesce();
            quiet_phase = 1'b0;
        end

        if (expected_words.size() != 0)
            report_mismatch("words never delivered", expected_words.size(), 0);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/thlt_pkg.sv
hdl/tap_hold_layer_toggle_unit.sv
bench/testbench.sv
